@@ rtl/core/tmm_pkg.sv @@
package tmm_pkg;

   localparam int DELTA_WIDTH = 16;

   localparam logic [1:0] ACT_MOVE   = 2'd0;
   localparam logic [1:0] ACT_SCROLL = 2'd1;
   localparam logic [1:0] ACT_ARROW  = 2'd2;

   localparam logic [2:0] ARROW_NONE  = 3'd0;
   localparam logic [2:0] ARROW_UP    = 3'd1;
   localparam logic [2:0] ARROW_DOWN  = 3'd2;
   localparam logic [2:0] ARROW_LEFT  = 3'd3;
   localparam logic [2:0] ARROW_RIGHT = 3'd4;

   localparam int CSR_ADDR_WIDTH = 4;

   localparam logic [1:0] CSR_AXIS_LAYOUT     = 2'd0;
   localparam logic [1:0] CSR_SCROLL_DIV      = 2'd1;
   localparam logic [1:0] CSR_ARROW_THRESHOLD = 2'd2;

   localparam logic        AXIS_LAYOUT_RESET     = 1'b0;
   localparam logic [2:0]  SCROLL_DIV_RESET      = 3'd4;
   localparam logic [6:0]  ARROW_THRESHOLD_RESET = 7'd5;

   typedef struct packed {
      logic [1:0]                     action;
      logic signed [DELTA_WIDTH-1:0]  delta_x;
      logic signed [DELTA_WIDTH-1:0]  delta_y;
      logic                           is_left_side;
   } req_type;

   typedef struct packed {
      logic signed [7:0] report_x;
      logic signed [7:0] report_y;
      logic signed [7:0] report_h;
      logic signed [7:0] report_v;
      logic [2:0]        arrow_key;
   } rsp_type;

endpackage

@@ rtl/core/trackball_motion_mapper.sv @@
// Trackball motion mapper.
// Input beat: start with req_data (action, delta_x, delta_y, is_left_side).
// busy is always low, so a beat is taken on every cycle that start is high.
// Each beat yields exactly one result beat: rsp_valid is high for one cycle
// with rsp_data (pointer x/y, scroll h/v, arrow key).
// Each beat passes through the input register, then the result register.
// Throughput: one beat per cycle.
// The rate is set by the single path from the input register through the
// magnitude sum, gain pick and constant multiplies into the result register.
// The receiver cannot stall; results are never held or dropped.
// Configuration: APB registers at byte address 0 (axis_layout),
// 4 (scroll_div) and 8 (arrow_threshold); pready is always high.
// Write them only while no beat is in flight.
// Reset (synchronous, active high) clears the pipeline valids and returns
// the registers to axis_layout 0, scroll_div 4, arrow_threshold 5.
module trackball_motion_mapper
   import tmm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   localparam int DW = DELTA_WIDTH;
   localparam int PW = DW + 5;
   localparam logic [PW-1:0] CLIP_LIMIT = PW'(1280);
   localparam logic [23:0]   RECIP10    = 24'd6554;

   logic        axis_layout_ff, axis_layout_in;
   logic [2:0]  scroll_div_ff, scroll_div_in;
   logic [6:0]  arrow_threshold_ff, arrow_threshold_in;

   logic        in_vld_ff;
   req_type     in_data_ff;
   logic        out_vld_ff;
   rsp_type     out_data_ff, out_data_in;

   logic             csr_wr;
   logic [1:0]       csr_idx;

   logic [DW-1:0]    ax, ay;
   logic [DW:0]      sum_mag;
   logic [4:0]       gain;
   logic [6:0]       gx_mag, gy_mag;
   logic [2:0]       shamt;
   logic [6:0]       qx_mag, qy_mag;
   logic signed [7:0] gx, gy, qx, qy;
   logic [2:0]       key;

   function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
      mag = v[DW-1] ? (~v + DW'(1)) : v;
   endfunction

   function automatic logic [4:0] pick_gain(input logic [DW:0] s);
      logic [4:0] g;
      if (s > (DW+1)'(60))      g = 5'd30;
      else if (s > (DW+1)'(30)) g = 5'd15;
      else if (s > (DW+1)'(5))  g = 5'd10;
      else if (s > (DW+1)'(4))  g = 5'd9;
      else if (s > (DW+1)'(3))  g = 5'd7;
      else if (s > (DW+1)'(2))  g = 5'd5;
      else if (s > (DW+1)'(1))  g = 5'd2;
      else                      g = 5'd10;
      return g;
   endfunction

   // |d| * gain / 10, saturated at 127; divide by 10 via reciprocal multiply
   function automatic logic [6:0] scale_mag(input logic [DW-1:0] m,
                                            input logic [4:0] g);
      logic [PW-1:0] p;
      logic [23:0]   r;
      p = {5'd0, m} * {{DW{1'b0}}, g};
      r = {13'd0, p[10:0]} * RECIP10;
      if (p >= CLIP_LIMIT) return 7'd127;
      return r[22:16];
   endfunction

   function automatic logic signed [7:0] signed_of(input logic [6:0] m,
                                                   input logic neg);
      logic signed [7:0] v;
      v = $signed({1'b0, m});
      return neg ? -v : v;
   endfunction

   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_comb begin
      axis_layout_in     = axis_layout_ff;
      scroll_div_in      = scroll_div_ff;
      arrow_threshold_in = arrow_threshold_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_AXIS_LAYOUT:     axis_layout_in     = pwdata[0];
            CSR_SCROLL_DIV:      scroll_div_in      = pwdata[2:0];
            CSR_ARROW_THRESHOLD: arrow_threshold_in = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_AXIS_LAYOUT:     prdata = {31'd0, axis_layout_ff};
         CSR_SCROLL_DIV:      prdata = {29'd0, scroll_div_ff};
         CSR_ARROW_THRESHOLD: prdata = {25'd0, arrow_threshold_ff};
         default:             prdata = 32'd0;
      endcase
   end

   always_comb begin
      ax      = mag(in_data_ff.delta_x);
      ay      = mag(in_data_ff.delta_y);
      sum_mag = {1'b0, ax} + {1'b0, ay};
      gain    = pick_gain(sum_mag);
      gx_mag  = scale_mag(ax, gain);
      gy_mag  = scale_mag(ay, gain);
      gx      = signed_of(gx_mag, in_data_ff.delta_x[DW-1]);
      gy      = signed_of(gy_mag, in_data_ff.delta_y[DW-1]);
      shamt   = (scroll_div_ff == 3'd0) ? 3'd0 : scroll_div_ff - 3'd1;
      qx_mag  = gx_mag >> shamt;
      qy_mag  = gy_mag >> shamt;
      qx      = signed_of(qx_mag, in_data_ff.delta_x[DW-1]);
      qy      = signed_of(qy_mag, in_data_ff.delta_y[DW-1]);

      // dominant axis already exceeds the threshold whenever either does
      key = ARROW_NONE;
      if (ax > DW'(arrow_threshold_ff) || ay > DW'(arrow_threshold_ff)) begin
         if (ax > ay) key = in_data_ff.delta_x[DW-1] ? ARROW_UP : ARROW_DOWN;
         else         key = in_data_ff.delta_y[DW-1] ? ARROW_LEFT : ARROW_RIGHT;
      end

      out_data_in = '0;
      case (in_data_ff.action)
         ACT_MOVE: begin
            if (axis_layout_ff) begin
               out_data_in.report_x = gx;
               out_data_in.report_y = -gy;
            end else if (in_data_ff.is_left_side) begin
               out_data_in.report_x = -gy;
               out_data_in.report_y = -gx;
            end else begin
               out_data_in.report_x = gy;
               out_data_in.report_y = gx;
            end
         end
         ACT_SCROLL: begin
            if (axis_layout_ff) begin
               out_data_in.report_h = qx;
               out_data_in.report_v = qy;
            end else if (in_data_ff.is_left_side) begin
               out_data_in.report_h = -qy;
               out_data_in.report_v = qx;
            end else begin
               out_data_in.report_h = qy;
               out_data_in.report_v = -qx;
            end
         end
         ACT_ARROW: out_data_in.arrow_key = key;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_layout_ff     <= AXIS_LAYOUT_RESET;
         scroll_div_ff      <= SCROLL_DIV_RESET;
         arrow_threshold_ff <= ARROW_THRESHOLD_RESET;
         in_vld_ff          <= 1'b0;
         out_vld_ff         <= 1'b0;
      end else begin
         axis_layout_ff     <= axis_layout_in;
         scroll_div_ff      <= scroll_div_in;
         arrow_threshold_ff <= arrow_threshold_in;
         in_vld_ff          <= start && !busy;
         out_vld_ff         <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= req_data;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted beat gave no result two cycles later");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result beat without an accepted input beat");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.arrow_key != ARROW_NONE) |->
         (rsp_data.report_x == 8'sd0 && rsp_data.report_y == 8'sd0 &&
          rsp_data.report_h == 8'sd0 && rsp_data.report_v == 8'sd0))
      else $error("arrow key together with motion");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.report_x != 8'sh80 && rsp_data.report_y != 8'sh80 &&
                     rsp_data.report_h != 8'sh80 && rsp_data.report_v != 8'sh80 &&
                     rsp_data.arrow_key <= ARROW_RIGHT))
      else $error("result field out of range");

   a_move_scroll: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.report_x != 8'sd0 || rsp_data.report_y != 8'sd0)) |->
         (rsp_data.report_h == 8'sd0 && rsp_data.report_v == 8'sd0))
      else $error("pointer and scroll motion in one result");
`endif

endmodule

@@ tb/tb_trackball_motion_mapper.sv @@
`timescale 1ns / 100ps

module tb_trackball_motion_mapper
   import tmm_pkg::*;
();

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int GAP_MAX = 14;
   localparam int DRAIN_LIMIT = 200;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   logic       layout_cfg = AXIS_LAYOUT_RESET;
   logic [2:0] scroll_div_cfg = SCROLL_DIV_RESET;
   logic [6:0] threshold_cfg = ARROW_THRESHOLD_RESET;

   rsp_type expected_reports[$];
   rsp_type want;
   int      mismatch_count = 0;
   int      beats_seen = 0;

   trackball_motion_mapper dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   function automatic int magnitude(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic int clip_report(int v);
      return v < -127 ? -127 : (v > 127 ? 127 : v);
   endfunction

   // Expected report for one motion sample under the current register copy.
   function automatic rsp_type map_motion(req_type item);
      int      dx;
      int      dy;
      int      s;
      int      g;
      int      gx;
      int      gy;
      int      qx;
      int      qy;
      int      rx;
      int      ry;
      int      rh;
      int      rv;
      int      t;
      int      divisor;
      rsp_type r;
      dx = int'(item.delta_x);
      dy = int'(item.delta_y);
      rx = 0;
      ry = 0;
      rh = 0;
      rv = 0;
      r = '0;
      r.arrow_key = ARROW_NONE;
      if (item.action == ACT_MOVE || item.action == ACT_SCROLL) begin
         s = magnitude(dx) + magnitude(dy);
         if (s > 60) g = 30;
         else if (s > 30) g = 15;
         else if (s > 5) g = 10;
         else if (s == 5) g = 9;
         else if (s == 4) g = 7;
         else if (s == 3) g = 5;
         else if (s == 2) g = 2;
         else g = 10;
         gx = clip_report((dx * g) / 10);
         gy = clip_report((dy * g) / 10);
         if (item.action == ACT_MOVE) begin
            if (layout_cfg == 1'b0) begin
               rx = item.is_left_side ? -gy : gy;
               ry = item.is_left_side ? -gx : gx;
            end else begin
               rx = gx;
               ry = -gy;
            end
         end else begin
            divisor = (scroll_div_cfg == 3'd0) ? 1 : (1 << (int'(scroll_div_cfg) - 1));
            qx = gx / divisor;
            qy = gy / divisor;
            if (layout_cfg == 1'b0) begin
               rh = item.is_left_side ? -qy : qy;
               rv = item.is_left_side ? qx : -qx;
            end else begin
               rh = qx;
               rv = qy;
            end
         end
      end else if (item.action == ACT_ARROW) begin
         t = int'(threshold_cfg);
         if (magnitude(dx) > t || magnitude(dy) > t) begin
            if (magnitude(dx) > magnitude(dy)) begin
               if (dx < -t) r.arrow_key = ARROW_UP;
               else if (dx > t) r.arrow_key = ARROW_DOWN;
            end else begin
               if (dy < -t) r.arrow_key = ARROW_LEFT;
               else if (dy > t) r.arrow_key = ARROW_RIGHT;
            end
         end
      end
      r.report_x = rx[7:0];
      r.report_y = ry[7:0];
      r.report_h = rh[7:0];
      r.report_v = rv[7:0];
      return r;
   endfunction

   function automatic req_type motion(logic [1:0] action, int dx, int dy, logic left);
      req_type item;
      item.action = action;
      item.delta_x = dx[DELTA_WIDTH-1:0];
      item.delta_y = dy[DELTA_WIDTH-1:0];
      item.is_left_side = left;
      return item;
   endfunction

   function automatic int random_delta();
      int v;
      case ($urandom_range(0, 4))
         0: v = int'($urandom_range(0, 12)) - 6;
         1: v = int'($urandom_range(0, 140)) - 70;
         2: v = int'($urandom_range(0, 600)) - 300;
         3: v = $signed($urandom);
         default: begin
            v = int'(threshold_cfg) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic req_type random_motion();
      logic [1:0] action;
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 4:  action = ACT_MOVE;
         5, 6, 7, 8, 9:  action = ACT_SCROLL;
         15:             action = ACT_UNUSED;
         default:        action = ACT_ARROW;
      endcase
      return motion(action, random_delta(), random_delta(), 1'($urandom_range(0, 1)));
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] beat %0d: %s", $time, beats_seen, msg);
      mismatch_count++;
   endtask

   task automatic send_motion(req_type item, int max_gap);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      expected_reports.push_back(map_motion(item));
   endtask

   // Stop sending and let every outstanding beat come back.
   task automatic drain_reports();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         CSR_AXIS_LAYOUT:     layout_cfg = value[0];
         CSR_SCROLL_DIV:      scroll_div_cfg = value[2:0];
         CSR_ARROW_THRESHOLD: threshold_cfg = value[6:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic layout, logic [2:0] div, logic [6:0] thr);
      drain_reports();
      write_csr(CSR_AXIS_LAYOUT, {31'd0, layout});
      write_csr(CSR_SCROLL_DIV, {29'd0, div});
      write_csr(CSR_ARROW_THRESHOLD, {25'd0, thr});
   endtask

   task automatic test_move_gain_steps();
      send_motion(motion(ACT_MOVE, 0, 0, 1'b0), GAP_MAX);
      send_motion(motion(ACT_MOVE, 1, 0, 1'b0), GAP_MAX);
      send_motion(motion(ACT_MOVE, -2, 0, 1'b1), GAP_MAX);
      send_motion(motion(ACT_MOVE, 3, 0, 1'b0), GAP_MAX);
      send_motion(motion(ACT_MOVE, 2, -2, 1'b0), GAP_MAX);
      send_motion(motion(ACT_MOVE, -5, 0, 1'b1), GAP_MAX);
      send_motion(motion(ACT_MOVE, 6, 0, 1'b0), GAP_MAX);
      send_motion(motion(ACT_MOVE, 31, 0, 1'b0), GAP_MAX);
      send_motion(motion(ACT_MOVE, 40, -21, 1'b1), GAP_MAX);
      send_motion(motion(ACT_MOVE, 32767, -32768, 1'b0), GAP_MAX);
      send_motion(motion(ACT_MOVE, -32768, -32768, 1'b1), GAP_MAX);
   endtask

   task automatic test_scroll_paths();
      send_motion(motion(ACT_SCROLL, 7, -9, 1'b0), GAP_MAX);
      send_motion(motion(ACT_SCROLL, -25, 3, 1'b1), GAP_MAX);
      send_motion(motion(ACT_SCROLL, 32767, 32767, 1'b0), GAP_MAX);
      send_motion(motion(ACT_SCROLL, -32768, 1, 1'b1), GAP_MAX);
   endtask

   task automatic test_arrow_keys();
      send_motion(motion(ACT_ARROW, -10, 3, 1'b0), GAP_MAX);
      send_motion(motion(ACT_ARROW, 10, 3, 1'b1), GAP_MAX);
      send_motion(motion(ACT_ARROW, 3, -10, 1'b0), GAP_MAX);
      send_motion(motion(ACT_ARROW, 3, 10, 1'b0), GAP_MAX);
      send_motion(motion(ACT_ARROW, 5, -5, 1'b0), GAP_MAX);
      send_motion(motion(ACT_ARROW, 6, 6, 1'b0), GAP_MAX);
      send_motion(motion(ACT_ARROW, -32768, 32767, 1'b1), GAP_MAX);
   endtask

   task automatic test_unused_action();
      send_motion(motion(ACT_UNUSED, 100, -100, 1'b1), GAP_MAX);
      send_motion(motion(ACT_UNUSED, -32768, 32767, 1'b0), 0);
   endtask

   // Random traffic across register settings, extremes first; bursty and
   // gapped phases alternate.
   task automatic test_register_sweep();
      logic       layouts[8] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      logic [2:0] divs[8]    = '{3'd1, 3'd7, 3'd0, 3'd1, 3'd7, 3'd3, 3'd2, 3'd4};
      logic [6:0] thrs[8]    = '{7'd0, 7'd127, 7'd20, 7'd127, 7'd0, 7'd9, 7'd60, 7'd5};
      for (int p = 0; p < 8; p++) begin
         if (p >= 5) begin
            divs[p] = 3'($urandom_range(0, 7));
            thrs[p] = 7'($urandom_range(0, 127));
         end
         apply_settings(layouts[p], divs[p], thrs[p]);
         for (int i = 0; i < 62; i++)
            send_motion(random_motion(), (p % 2 == 1) ? 0 : GAP_MAX);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         beats_seen++;
         if (expected_reports.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = expected_reports.pop_front();
            if (rsp_data.report_x !== want.report_x)
               report_mismatch($sformatf("report_x got %0d want %0d",
                  $signed(rsp_data.report_x), $signed(want.report_x)));
            if (rsp_data.report_y !== want.report_y)
               report_mismatch($sformatf("report_y got %0d want %0d",
                  $signed(rsp_data.report_y), $signed(want.report_y)));
            if (rsp_data.report_h !== want.report_h)
               report_mismatch($sformatf("report_h got %0d want %0d",
                  $signed(rsp_data.report_h), $signed(want.report_h)));
            if (rsp_data.report_v !== want.report_v)
               report_mismatch($sformatf("report_v got %0d want %0d",
                  $signed(rsp_data.report_v), $signed(want.report_v)));
            if (rsp_data.arrow_key !== want.arrow_key)
               report_mismatch($sformatf("arrow_key got %0d want %0d",
                  rsp_data.arrow_key, want.arrow_key));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_move_gain_steps();
      test_scroll_paths();
      test_arrow_keys();
      test_unused_action();
      test_register_sweep();
      drain_reports();
      if (expected_reports.size() != 0)
         report_mismatch($sformatf("%0d result beats never arrived",
            expected_reports.size()));
      if (mismatch_count == 0) begin
         $display("trackball_motion_mapper test passed");
      end else begin
         $display("trackball_motion_mapper test failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("trackball_motion_mapper test failed");
      $finish;
   end

endmodule
